// ----- rtl/core/pipt_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the point-in-polygon test block
// no dependencies; imported by every module under rtl/core

package pipt_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_WIDTH  = 32;

	// fixed field widths of the stream items and the config register
	localparam int INDEX_W  = 6;
	localparam int VCOUNT_W = 7;
	localparam int IN_W     = 32;

	// derived widths
	localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int DW    = COORD_WIDTH + 1;
	localparam int PW    = 2 * DW;

	// item kinds carried in tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} pipt_state_t;

	// controller to datapath
	typedef struct packed {
		logic             start;
		logic             wr_en;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             edge_en;
		logic             out_load;
	} pipt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} pipt_sts_t;

endpackage

// ----- rtl/core/pipt_ctrl.sv -----
`timescale 1ns / 1ps
// controller for the point-in-polygon test: item intake and edge walk sequencing
// depends on pipt_pkg

module pipt_ctrl
	import pipt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_valid,
	input  logic                s_op,
	output logic                s_ready,
	input  logic                cfg_we,
	input  logic [VCOUNT_W-1:0] cfg_wdata,
	input  pipt_sts_t           sts,
	output pipt_cmd_t           cmd
);

	pipt_state_t        state_q, state_d;
	logic [VCOUNT_W-1:0] vcount_q;
	logic [IDX_W-1:0]    cnt_q, cnt_d;
	logic [IDX_W-1:0]    last_q, last_d;
	logic [CNT_W-1:0]    n_clamp;
	logic                accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			last_q  <= last_d;
		end
	end

	// vertex count above the store depth uses the whole store
	assign n_clamp = (32'(vcount_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
	                                               : CNT_W'(vcount_q);
	assign s_ready = (state_q == ST_IDLE);
	assign accept  = s_valid && s_ready;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		last_d       = last_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_op == OP_LOAD) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.start = 1'b1;
						last_d    = IDX_W'(n_clamp - CNT_W'(1));
						cnt_d     = '0;
						if (n_clamp == '0) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_PRIME;
						end
					end
				end
			end
			ST_PRIME: begin
				// fetch the last vertex so the first edge has its start point
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = last_q;
				state_d     = ST_WALK;
			end
			ST_WALK: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = cnt_q;
				cmd.edge_en = 1'b1;
				cnt_d       = cnt_q + IDX_W'(1);
				if (cnt_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/pipt_dp.sv -----
`timescale 1ns / 1ps
// datapath for the point-in-polygon test: vertex store, edge crossing pipeline,
// parity flag and output register; depends on pipt_pkg

module pipt_dp
	import pipt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  pipt_cmd_t            cmd,
	output pipt_sts_t            sts,
	input  logic [INDEX_W-1:0]   vertex_index,
	input  logic [IN_W-1:0]      coord_x,
	input  logic [IN_W-1:0]      coord_z,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 inside_res
);

	logic [2*COORD_WIDTH-1:0] mem [MAX_VERTICES];

	logic signed [COORD_WIDTH-1:0] px_q, pz_q;
	logic signed [COORD_WIDTH-1:0] rd_x_s1, rd_z_s1;
	logic signed [COORD_WIDTH-1:0] prev_x_q, prev_z_q;
	logic                          rd_v_s1, edge_s1;

	logic signed [DW-1:0] dxp_d, dz_d, dxe_d, dzp_d;
	logic signed [DW-1:0] dxp_s2, dz_s2, dxe_s2, dzp_s2;
	logic                 cross_d;
	logic                 v_s2, cross_s2, dzpos_s2;

	logic signed [PW-1:0] a_s3, b_s3;
	logic                 v_s3, cross_s3, dzpos_s3;
	logic                 left;

	logic parity_q;
	logic out_valid_q, res_q;

	// vertex store, x in the low half
	always_ff @(posedge clk) begin
		if (cmd.wr_en && (32'(vertex_index) < MAX_VERTICES)) begin
			mem[IDX_W'(vertex_index)] <= {coord_z[COORD_WIDTH-1:0], coord_x[COORD_WIDTH-1:0]};
		end
		if (cmd.rd_en) begin
			{rd_z_s1, rd_x_s1} <= mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= coord_x[COORD_WIDTH-1:0];
			pz_q <= coord_z[COORD_WIDTH-1:0];
		end
		if (rd_v_s1) begin
			prev_x_q <= rd_x_s1;
			prev_z_q <= rd_z_s1;
		end
	end

	// edge from prev (j) to current read (i)
	always_comb begin
		dxp_d   = DW'(px_q) - DW'(rd_x_s1);
		dz_d    = DW'(prev_z_q) - DW'(rd_z_s1);
		dxe_d   = DW'(prev_x_q) - DW'(rd_x_s1);
		dzp_d   = DW'(pz_q) - DW'(rd_z_s1);
		cross_d = (rd_z_s1 > pz_q) != (prev_z_q > pz_q);
	end

	always_ff @(posedge clk) begin
		dxp_s2   <= dxp_d;
		dz_s2    <= dz_d;
		dxe_s2   <= dxe_d;
		dzp_s2   <= dzp_d;
		cross_s2 <= cross_d;
		dzpos_s2 <= (prev_z_q > rd_z_s1);
		a_s3     <= PW'(dxp_s2) * PW'(dz_s2);
		b_s3     <= PW'(dxe_s2) * PW'(dzp_s2);
		cross_s3 <= cross_s2;
		dzpos_s3 <= dzpos_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			edge_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.rd_en;
			edge_s1 <= cmd.rd_en && cmd.edge_en;
			v_s2    <= rd_v_s1 && edge_s1;
			v_s3    <= v_s2;
		end
	end

	// strictly left of the crossing, sign of dz decides the direction
	assign left = dzpos_s3 ? (a_s3 < b_s3) : (b_s3 < a_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (cmd.start) begin
			parity_q <= 1'b0;
		end else if (v_s3 && cross_s3 && left) begin
			parity_q <= !parity_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q <= parity_q;
		end
	end

	assign sts.pipe_busy = rd_v_s1 || v_s2 || v_s3;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign inside_res    = res_q;

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an unread result");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("output valid rose without a result load");

	a_no_write_during_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !sts.pipe_busy)
		else $error("vertex written while an edge walk is in flight");

	a_start_clears_parity: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !parity_q)
		else $error("parity not cleared at test start");

endmodule

// ----- rtl/core/point_in_polygon_test_top.sv -----
`timescale 1ns / 1ps
// top level of the point-in-polygon test block
// depends on pipt_pkg, pipt_ctrl and pipt_dp

// usage
// - input stream s_*: tuser selects the item kind, 0 = load vertex, 1 = test point
//   a load writes coord_x/coord_z into store slot vertex_index and gives no result
//   a test returns one result item on m_* with tdata[0] = 1 when the point is inside
// - config: cfg_we with cfg_wdata sets vertex_count (vertices used by tests, above
//   the store depth means the whole store); write it only while the block is idle
// - crossing-number rule over every edge, exact signed cross-multiplication
// - timing: a load leaves the sequencer idle and ready for the next item; a test walks
//   one edge per cycle through a vertex store read, then a 3-stage subtract/multiply/
//   compare pipeline; the next item can be taken in the same cycle as the result shows
// - with zero vertices no edge is walked and the result is outside
// - s_tready is high only while the sequencer is idle; loads are still taken while
//   a finished result waits in the output register
// - a stalled receiver holds the result; a following test finishes its walk and
//   waits until the output register frees up
// - reset clears the sequencer, vertex_count and the output valid; the vertex
//   store is not cleared and must be loaded before use
module point_in_polygon_test_top
	import pipt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [71:0]         s_tdata,   // vertex_index[5:0], coord_x[37:6], coord_z[69:38], zero pad
	input  logic                s_tuser,   // operation
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // inside_res[0], zero pad
	input  logic                cfg_we,
	input  logic [VCOUNT_W-1:0] cfg_wdata  // vertex_count
);

	pipt_cmd_t cmd;
	pipt_sts_t sts;
	logic      inside_res;

	// sequencer: intake, edge walk and result handoff
	pipt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_tvalid),
		.s_op      (s_tuser),
		.s_ready   (s_tready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store, crossing pipeline and output register
	pipt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.vertex_index (s_tdata[INDEX_W-1:0]),
		.coord_x      (s_tdata[INDEX_W +: IN_W]),
		.coord_z      (s_tdata[INDEX_W+IN_W +: IN_W]),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.inside_res   (inside_res)
	);

	assign m_tdata = {7'b0, inside_res};

endmodule
